// ===== sv/rc_frame_parser_autolength_unit_macros.svh =====
// ----------------------------------------------------------------------------
// RC frame parser assertion macros
// Clocked, reset-qualified property shorthands used by the parser decoder.
// ----------------------------------------------------------------------------
`ifndef RC_FRAME_PARSER_AUTOLENGTH_UNIT_MACROS_SVH
`define RC_FRAME_PARSER_AUTOLENGTH_UNIT_MACROS_SVH

// same-cycle implication
`define RCFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RCFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rcfp_pkg.sv =====
// ----------------------------------------------------------------------------
// RC frame parser package
// Shared types and constants for the frame parser with learned length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rcfp_pkg;

    localparam logic [7:0] START_CODE       = 8'h87;
    localparam int         REQUIRED_MATCHES = 3;
    localparam int         MATCH_W          = 4;

    localparam logic [MATCH_W-1:0] MATCH_RELOAD = MATCH_W'(REQUIRED_MATCHES);

    localparam logic [2:0] LEN_NONE  = 3'd0;
    localparam logic [2:0] LEN_SHORT = 3'd4;
    localparam logic [2:0] LEN_LONG  = 3'd5;

    localparam logic signed [7:0] CH3_HIGH = 8'sd100;
    localparam logic signed [7:0] CH3_LOW  = -8'sd100;

    typedef enum logic [2:0] {
        PH_WAIT  = 3'd0,
        PH_STEER = 3'd1,
        PH_THROT = 3'd2,
        PH_FLAGS = 3'd3,
        PH_FIFTH = 3'd4,
        PH_EXTRA = 3'd5
    } phase_t;

    typedef struct packed {
        logic signed [7:0] steering;
        logic        [7:0] steering_magnitude;
        logic signed [7:0] throttle;
        logic        [7:0] throttle_magnitude;
        logic signed [7:0] ch3_position;
        logic              startup_neutral;
        logic        [2:0] frame_length;
    } result_t;

    function automatic logic [7:0] magnitude_of(input logic [7:0] b);
        magnitude_of = b[7] ? (~b + 8'd1) : b;
    endfunction

endpackage

// ===== sv/rc_frame_parser_autolength_unit.sv =====
// ----------------------------------------------------------------------------
// RC frame parser with learned frame length
// The completing word is registered in the input stage, then its result in out_reg.
// Throughput: one word per cycle unless m_ready stalls; then both registers hold.
// Reset (aresetn low, synchronous): parser waits for a start byte, no length learned,
// reader enabled, no result pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc_frame_parser_autolength_unit
    import rcfp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_reader_enable,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic        [7:0] s_rx_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic signed [7:0] m_steering,
    output logic        [7:0] m_steering_magnitude,
    output logic signed [7:0] m_throttle,
    output logic        [7:0] m_throttle_magnitude,
    output logic signed [7:0] m_ch3_position,
    output logic              m_startup_neutral,
    output logic        [2:0] m_frame_length
);

    logic       enable_reg;
    logic       word_valid;
    logic [7:0] word_byte;
    logic       take;
    logic       emit;
    result_t    result;
    result_t    out_reg;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign cfg_ready = 1'b1;
    assign take      = word_valid && (!out_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            enable_reg <= cfg_reader_enable;
        end
    end

    rcfp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .take       (take),
        .word_valid (word_valid),
        .word_byte  (word_byte)
    );

    rcfp_decoder u_dec (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (take),
        .reader_enable (enable_reg),
        .rx_byte       (word_byte),
        .emit          (emit),
        .result        (result)
    );

    // hold the result until taken, load a new one when the decoder emits
    assign out_valid_next = (take && emit) || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && emit) begin
            out_reg <= result;
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_steering           = out_reg.steering;
    assign m_steering_magnitude = out_reg.steering_magnitude;
    assign m_throttle           = out_reg.throttle;
    assign m_throttle_magnitude = out_reg.throttle_magnitude;
    assign m_ch3_position       = out_reg.ch3_position;
    assign m_startup_neutral    = out_reg.startup_neutral;
    assign m_frame_length       = out_reg.frame_length;

endmodule

// ===== sv/rcfp_in_stage.sv =====
// ----------------------------------------------------------------------------
// RC frame parser input stage
// Registers one received word and releases it when the decoder takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcfp_in_stage
    import rcfp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       take,
    output logic       word_valid,
    output logic [7:0] word_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    assign word_valid = valid_reg;
    assign word_byte  = byte_reg;

endmodule

// ===== sv/rcfp_decoder.sv =====
// ----------------------------------------------------------------------------
// RC frame parser decoder
// Frame phase tracking, length learning and result formatting per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rc_frame_parser_autolength_unit_macros.svh"

module rcfp_decoder
    import rcfp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  logic       reader_enable,
    input  logic [7:0] rx_byte,
    output logic       emit,
    output result_t    result
);

    phase_t               phase_reg,   phase_next;
    logic [7:0]           steer_reg,   steer_next;
    logic [7:0]           throt_reg,   throt_next;
    logic [7:0]           flags_reg,   flags_next;
    logic [2:0]           learned_reg, learned_next;
    logic [MATCH_W-1:0]   matches_reg, matches_next;
    logic [2:0]           seen_len;
    logic                 learning;
    logic                 emit_next;
    logic                 len_known;
    logic                 word_en;

    assign learning = (matches_reg != '0);
    assign seen_len = (phase_reg == PH_FIFTH) ? LEN_SHORT : LEN_LONG;

    always_comb begin
        phase_next   = phase_reg;
        steer_next   = steer_reg;
        throt_next   = throt_reg;
        flags_next   = flags_reg;
        learned_next = learned_reg;
        matches_next = matches_reg;
        emit_next    = 1'b0;
        if (fire && reader_enable) begin
            if (rx_byte == START_CODE) begin
                if (learning && (phase_reg == PH_FIFTH || phase_reg == PH_EXTRA)) begin
                    if (learned_reg == seen_len) begin
                        matches_next = matches_reg - MATCH_W'(1);
                    end else begin
                        learned_next = seen_len;
                        matches_next = MATCH_RELOAD;
                    end
                end
                phase_next = PH_STEER;
            end else begin
                case (phase_reg)
                    PH_STEER: begin
                        steer_next = rx_byte;
                        phase_next = PH_THROT;
                    end
                    PH_THROT: begin
                        throt_next = rx_byte;
                        phase_next = PH_FLAGS;
                    end
                    PH_FLAGS: begin
                        flags_next = rx_byte;
                        if (learning || learned_reg > LEN_SHORT) begin
                            phase_next = PH_FIFTH;
                        end else begin
                            emit_next  = 1'b1;
                            phase_next = PH_WAIT;
                        end
                    end
                    PH_FIFTH: begin
                        if (learning) begin
                            phase_next = PH_EXTRA;
                        end else begin
                            emit_next  = 1'b1;
                            phase_next = PH_WAIT;
                        end
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_WAIT;
            steer_reg   <= '0;
            throt_reg   <= '0;
            flags_reg   <= '0;
            learned_reg <= LEN_NONE;
            matches_reg <= MATCH_RELOAD;
        end else begin
            phase_reg   <= phase_next;
            steer_reg   <= steer_next;
            throt_reg   <= throt_next;
            flags_reg   <= flags_next;
            learned_reg <= learned_next;
            matches_reg <= matches_next;
        end
    end

    assign emit                      = emit_next;
    assign result.steering           = steer_next;
    assign result.steering_magnitude = magnitude_of(steer_next);
    assign result.throttle           = throt_next;
    assign result.throttle_magnitude = magnitude_of(throt_next);
    assign result.ch3_position       = flags_next[0] ? CH3_HIGH : CH3_LOW;
    assign result.startup_neutral    = flags_next[4];
    assign result.frame_length       = learned_reg;

    assign len_known = (learned_reg == LEN_SHORT || learned_reg == LEN_LONG);
    assign word_en   = fire && reader_enable;

    `RCFP_ASSERT_NOW(a_emit_len, emit, len_known, "emit without learned length")
    `RCFP_ASSERT_NOW(a_emit_learned, emit, (matches_reg == '0), "emit while still learning")
    `RCFP_ASSERT_NOW(a_match_range, 1'b1, matches_reg <= MATCH_RELOAD, "match count out of range")
    `RCFP_ASSERT_NEXT(a_hold, !word_en, $stable({phase_reg, matches_reg}), "idle state moved")

endmodule

// ===== tb/sv/tb_rc_frame_parser_autolength_unit.sv =====
// ----------------------------------------------------------------------------
// Testbench for the RC frame parser with learned frame length
// Feeds the parser raw serial words with random gaps on both sides: stray
// words, reader-disabled stretches, frame-length learning with mixed lengths,
// extreme field values and random well-formed and broken frames. Each decoded
// frame is checked field by field against an in-order queue of decodes
// predicted from a behavioral copy of the parser state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rc_frame_parser_autolength_unit
    import rcfp_pkg::*;
();

    localparam int RESULT_LATENCY = 2;
    localparam int SETTLE_CYCLES  = RESULT_LATENCY + 3;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_WORDS   = 750;
    localparam int CALM_WORDS     = 120;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_reader_enable;
    logic              s_valid;
    logic              s_ready;
    logic        [7:0] s_rx_byte;
    logic              m_valid;
    logic              m_ready;
    logic signed [7:0] m_steering;
    logic        [7:0] m_steering_magnitude;
    logic signed [7:0] m_throttle;
    logic        [7:0] m_throttle_magnitude;
    logic signed [7:0] m_ch3_position;
    logic              m_startup_neutral;
    logic        [2:0] m_frame_length;

    // parser state as the testbench sees it
    phase_t             frame_phase;
    logic [7:0]         held_steering;
    logic [7:0]         held_throttle;
    logic [7:0]         held_flags;
    logic [2:0]         seen_length;
    logic [MATCH_W-1:0] matches_needed;
    logic               reader_on;

    result_t    pending_frames[$];
    int         mismatches    = 0;
    int         words_sent    = 0;
    int         frames_seen   = 0;
    int         reader_writes = 0;
    bit         calm          = 1'b0;
    logic [2:0] target_len;

    rc_frame_parser_autolength_unit u_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_reader_enable    (cfg_reader_enable),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_rx_byte            (s_rx_byte),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_steering           (m_steering),
        .m_steering_magnitude (m_steering_magnitude),
        .m_throttle           (m_throttle),
        .m_throttle_magnitude (m_throttle_magnitude),
        .m_ch3_position       (m_ch3_position),
        .m_startup_neutral    (m_startup_neutral),
        .m_frame_length       (m_frame_length)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [7:0] abs_byte(input logic [7:0] b);
        return b[7] ? 8'(9'd256 - {1'b0, b}) : b;
    endfunction

    function automatic result_t frame_result();
        result_t r;
        r.steering           = held_steering;
        r.steering_magnitude = abs_byte(held_steering);
        r.throttle           = held_throttle;
        r.throttle_magnitude = abs_byte(held_throttle);
        r.ch3_position       = held_flags[0] ? CH3_HIGH : CH3_LOW;
        r.startup_neutral    = held_flags[4];
        r.frame_length       = seen_length;
        return r;
    endfunction

    // advance the parser state by one word; return 1 when a frame decodes
    function automatic bit decode_word(input logic [7:0] b, output result_t r);
        logic [2:0] ended_len;
        r = '0;
        if (!reader_on) return 1'b0;
        if (b == START_CODE) begin
            if (matches_needed != 0 &&
                (frame_phase == PH_FIFTH || frame_phase == PH_EXTRA)) begin
                ended_len = (frame_phase == PH_FIFTH) ? LEN_SHORT : LEN_LONG;
                if (seen_length == ended_len) begin
                    matches_needed = matches_needed - MATCH_W'(1);
                end else begin
                    seen_length    = ended_len;
                    matches_needed = MATCH_RELOAD;
                end
            end
            frame_phase = PH_STEER;
            return 1'b0;
        end
        case (frame_phase)
            PH_STEER: begin
                held_steering = b;
                frame_phase   = PH_THROT;
            end
            PH_THROT: begin
                held_throttle = b;
                frame_phase   = PH_FLAGS;
            end
            PH_FLAGS: begin
                held_flags = b;
                if (matches_needed != 0 || seen_length > LEN_SHORT) begin
                    frame_phase = PH_FIFTH;
                end else begin
                    r           = frame_result();
                    frame_phase = PH_WAIT;
                    return 1'b1;
                end
            end
            PH_FIFTH: begin
                if (matches_needed != 0) begin
                    frame_phase = PH_EXTRA;
                end else begin
                    r           = frame_result();
                    frame_phase = PH_WAIT;
                    return 1'b1;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic logic [7:0] rand_data();
        logic [7:0] b;
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 5))
                0: b = 8'h80;
                1: b = 8'h7F;
                2: b = 8'h00;
                3: b = 8'hFF;
                4: b = 8'd100;
                default: b = 8'h9C;
            endcase
            return b;
        end
        do b = 8'($urandom_range(0, 255)); while (b == START_CODE);
        return b;
    endfunction

    task automatic send_word(input logic [7:0] b);
        result_t r;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        if (decode_word(b, r)) pending_frames.push_back(r);
        if (reader_on) words_sent++;
    endtask

    task automatic send_frame(input logic [2:0] len, input logic [7:0] st,
                              input logic [7:0] th, input logic [7:0] fl);
        send_word(START_CODE);
        send_word(st);
        send_word(th);
        send_word(fl);
        if (len == LEN_LONG) send_word(rand_data());
    endtask

    // drain outstanding decodes, then write the reader enable
    task automatic set_reader(input logic en);
        s_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_reader_enable <= en;
        cfg_valid         <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reader_on = en;
        reader_writes++;
    endtask

    task automatic test_startup_learning();
        send_word(8'h00);
        send_word(8'hFF);
        send_word(8'h55);
        set_reader(1'b0);
        send_word(START_CODE);
        send_word(8'h10);
        send_word(8'h20);
        set_reader(1'b1);
        send_frame(LEN_LONG, 8'h11, 8'h22, 8'h01);
        send_word(8'h33);
        send_frame(LEN_SHORT, 8'h44, 8'h55, 8'h10);
        send_word(START_CODE);
        send_word(8'h66);
        repeat (4) send_frame(target_len, rand_data(), rand_data(), rand_data());
        send_frame(target_len, 8'h80, 8'h7F, 8'h01);
    endtask

    task automatic test_extremes();
        send_frame(target_len, 8'h7F, 8'h80, 8'h10);
        send_frame(target_len, 8'h00, 8'hFF, 8'h11);
        send_frame(target_len, 8'hFF, 8'h00, 8'h00);
        send_frame(LEN_SHORT, 8'h81, 8'h01, 8'hEE);
        send_frame(LEN_LONG, 8'h9C, 8'h64, 8'hFF);
    endtask

    task automatic test_disable_midframe();
        send_word(START_CODE);
        send_word(8'hC8);
        set_reader(1'b0);
        send_frame(LEN_LONG, 8'h01, 8'h02, 8'h03);
        set_reader(1'b1);
        send_word(8'h38);
        send_word(8'h13);
        if (target_len == LEN_LONG) send_word(8'hAA);
    endtask

    task automatic test_random_traffic();
        int         kind;
        int         n;
        logic [2:0] other_len;
        other_len = (target_len == LEN_LONG) ? LEN_SHORT : LEN_LONG;
        while (words_sent < RANDOM_WORDS) begin
            if (words_sent > RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
            kind = $urandom_range(0, 39);
            if (kind < 28) begin
                send_frame(target_len, rand_data(), rand_data(), rand_data());
            end else if (kind < 31) begin
                send_word(START_CODE);
                n = $urandom_range(0, 3);
                repeat (n) send_word(rand_data());
            end else if (kind < 33) begin
                send_frame(other_len, rand_data(), rand_data(), rand_data());
            end else if (kind < 36) begin
                n = $urandom_range(1, 4);
                repeat (n) send_word(8'($urandom_range(0, 255)));
            end else if (kind < 38) begin
                send_frame(target_len, rand_data(), rand_data(), rand_data());
                n = $urandom_range(1, 3);
                repeat (n) send_word(rand_data());
            end else begin
                set_reader(1'b0);
                n = $urandom_range(1, 6);
                repeat (n) send_word(8'($urandom_range(0, 255)));
                set_reader(1'b1);
            end
        end
    endtask

    initial begin
        aresetn           <= 1'b0;
        cfg_valid         <= 1'b0;
        cfg_reader_enable <= 1'b1;
        s_valid           <= 1'b0;
        s_rx_byte         <= 8'h00;
        frame_phase    = PH_WAIT;
        held_steering  = 8'h00;
        held_throttle  = 8'h00;
        held_flags     = 8'h00;
        seen_length    = LEN_NONE;
        matches_needed = MATCH_RELOAD;
        reader_on      = 1'b1;
        target_len     = $urandom_range(0, 1) ? LEN_LONG : LEN_SHORT;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_startup_learning();
        test_extremes();
        test_disable_midframe();
        test_random_traffic();

        s_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES * 2) @(posedge aclk);

        $display("Covered %0d words and %0d decoded frames, learned length %0d,",
                 words_sent, frames_seen, target_len);
        $display("with %0d reader enable writes and random gaps on both channels.",
                 reader_writes);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // result channel stalls
    initial begin
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            frames_seen++;
            if (pending_frames.size() == 0) begin
                $error("decoded frame with none expected");
                mismatches++;
            end else begin
                want = pending_frames.pop_front();
                check_field("steering", want.steering, m_steering);
                check_field("steering_magnitude", want.steering_magnitude,
                            m_steering_magnitude);
                check_field("throttle", want.throttle, m_throttle);
                check_field("throttle_magnitude", want.throttle_magnitude,
                            m_throttle_magnitude);
                check_field("ch3_position", want.ch3_position, m_ch3_position);
                check_field("startup_neutral", 8'(want.startup_neutral),
                            8'(m_startup_neutral));
                check_field("frame_length", 8'(want.frame_length), 8'(m_frame_length));
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/rcfp_pkg.sv
sv/rcfp_in_stage.sv
sv/rcfp_decoder.sv
sv/rc_frame_parser_autolength_unit.sv
tb/sv/tb_rc_frame_parser_autolength_unit.sv
